>>> sv/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg: shared definitions for the IPv4 dotted-quad parser
// Character codes, field widths and limits that the parser, its channel
// interfaces and its checker all use.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  localparam int CH_W    = 8;
  localparam int ADDR_W  = 32;
  localparam int OCTET_W = 10;
  localparam int PART_W  = 24;

  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT  = 8'h2e;

  localparam logic [OCTET_W-1:0] OCTET_MAX = 10'd255;
  localparam logic [OCTET_W-1:0] RADIX     = 10'd10;

  localparam logic [1:0] DIGITS_MAX = 2'd3;
  localparam logic [1:0] DOTS_FULL  = 2'd3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

endpackage

>>> sv/ipv4dq_in_if.sv
// ----------------------------------------------------------------------------
// ipv4dq_in_if: character channel of the IPv4 dotted-quad parser
// Carries one character or end marker per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface ipv4dq_in_if;
  import ipv4dq_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [CH_W-1:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);

endinterface

>>> sv/ipv4dq_out_if.sv
// ----------------------------------------------------------------------------
// ipv4dq_out_if: result channel of the IPv4 dotted-quad parser
// Carries one parsed address and its error flag per transaction.
// ----------------------------------------------------------------------------
interface ipv4dq_out_if;
  import ipv4dq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              bad;

  modport source (output valid, output address, output bad, input ready);
  modport sink   (input valid, input address, input bad, output ready);

endinterface

>>> sv/ipv4_dotted_quad_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser: streaming IPv4 dotted-decimal address parser
// The chars channel delivers an address string one character per
// transaction (kind = 0), closed by an end transaction (kind = 1) whose ch
// field is ignored. Each end transaction produces one transaction on the
// result channel: the 32-bit address with the first octet in bits 31..24
// and bad = 0, or address = 0 and bad = 1 if the string is not a valid
// dotted quad. Character transactions produce no result.
// The parser takes one transaction per cycle while chars.ready is high. The
// result is registered in the output register at the edge that accepts the
// end transaction, and the parser is back in its start state for the next
// string at that same edge. The per-character update is a compare plus a
// multiply-by-ten add, computed combinationally ahead of the octet register.
// When the receiver stalls, the result stays in the output register and
// chars.ready drops only while a result is held and not taken.
// A synchronous reset clears the parse state and empties the output register.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser (
  input  logic         clk,
  input  logic         rst,
  ipv4dq_in_if.sink    chars,
  ipv4dq_out_if.source result
);
  import ipv4dq_pkg::*;

  logic [1:0]         digit_count, digit_count_next;
  logic [OCTET_W-1:0] octet_value, octet_value_next;
  logic [1:0]         dot_count, dot_count_next;
  logic [PART_W-1:0]  partial_address, partial_address_next;
  logic               error_seen, error_seen_next;

  logic               res_valid;
  logic [ADDR_W-1:0]  res_address;
  logic               res_bad;

  logic accept, is_digit, is_dot, octet_ok, end_bad;

  assign chars.ready = !res_valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  assign is_digit = (chars.ch >= CH_ZERO) && (chars.ch <= CH_NINE);
  assign is_dot   = (chars.ch == CH_DOT);
  assign octet_ok = (digit_count != 2'd0) && (octet_value <= OCTET_MAX);
  assign end_bad  = error_seen || (dot_count != DOTS_FULL) || !octet_ok;

  always_comb begin
    digit_count_next     = digit_count;
    octet_value_next     = octet_value;
    dot_count_next       = dot_count;
    partial_address_next = partial_address;
    error_seen_next      = error_seen;
    if (chars.kind == KIND_END) begin
      digit_count_next     = '0;
      octet_value_next     = '0;
      dot_count_next       = '0;
      partial_address_next = '0;
      error_seen_next      = 1'b0;
    end else if (!error_seen) begin
      priority if (is_digit) begin
        if (digit_count == DIGITS_MAX) begin
          error_seen_next = 1'b1;
        end else begin
          octet_value_next = OCTET_W'(octet_value * RADIX)
                             + {{(OCTET_W-4){1'b0}}, chars.ch[3:0]};
          digit_count_next = digit_count + 2'd1;
        end
      end else if (is_dot) begin
        if (dot_count == DOTS_FULL || !octet_ok) begin
          error_seen_next = 1'b1;
        end else begin
          partial_address_next = {partial_address[PART_W-9:0], octet_value[7:0]};
          dot_count_next       = dot_count + 2'd1;
          digit_count_next     = '0;
          octet_value_next     = '0;
        end
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count     <= '0;
      octet_value     <= '0;
      dot_count       <= '0;
      partial_address <= '0;
      error_seen      <= 1'b0;
    end else if (accept) begin
      digit_count     <= digit_count_next;
      octet_value     <= octet_value_next;
      dot_count       <= dot_count_next;
      partial_address <= partial_address_next;
      error_seen      <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (chars.ready) begin
      res_valid <= accept && (chars.kind == KIND_END);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars.kind == KIND_END) begin
      res_bad     <= end_bad;
      res_address <= end_bad ? '0 : {partial_address, octet_value[7:0]};
    end
  end

  assign result.valid   = res_valid;
  assign result.address = res_address;
  assign result.bad     = res_bad;

endmodule

>>> sv/ipv4dq_checker.sv
// ----------------------------------------------------------------------------
// ipv4dq_checker: port-level checks for the IPv4 dotted-quad parser
// Watches both channels of the parser and is bound to its top level.
// ----------------------------------------------------------------------------
module ipv4dq_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_kind,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [ipv4dq_pkg::ADDR_W-1:0] res_address,
  input logic                     res_bad
);
  import ipv4dq_pkg::*;

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_END |=> res_valid)
    else $error("End transaction did not produce a result.");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(in_valid && in_ready && in_kind == KIND_END))
    else $error("Result appeared without an end transaction.");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_bad |-> res_address == '0)
    else $error("Bad result carries a nonzero address.");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> in_ready)
    else $error("Input stalled while the output register is free.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_address) && $stable(res_bad))
    else $error("Stalled result changed.");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .in_kind    (chars.kind),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_address(result.address),
  .res_bad    (result.bad)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the IPv4 dotted-quad parser
// Feeds address strings one character per transaction, each closed by an
// end transaction. A short table of strings covers the boundary and error
// cases. Random strings follow: half are dotted quads with random octets,
// most others have one defect, some are random bytes. A parse model in
// the bench predicts random results, and all are compared in order, field
// by field. Both channels idle at random, with stretches of full rate.
// ----------------------------------------------------------------------------
module testbench;
  import ipv4dq_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int STALL_LIMIT  = 2000;
  localparam int SHAPES       = 7;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              bad;
  } addr_result_t;

  typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   ch;
    logic              fixed;
    logic [ADDR_W-1:0] address;
    logic              bad;
  } char_item_t;

  typedef struct packed {
    logic               err;
    logic [2:0]         dots;
    logic [1:0]         digits;
    logic [OCTET_W-1:0] octet;
    logic [PART_W-1:0]  partial;
  } parse_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipv4dq_in_if  chars_if ();
  ipv4dq_out_if result_if ();

  ipv4_dotted_quad_parser dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  string             shape_text [SHAPES] = '{"", "/", ":.", ".", "0000", "256.", "255.0.0.9"};
  logic [ADDR_W-1:0] shape_addr [SHAPES] = '{0, 0, 0, 0, 0, 0, 32'hFF00_0009};
  logic              shape_bad  [SHAPES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

  parse_state_t parse_state = '0;
  addr_result_t pending_addrs [$];
  int           mismatches  = 0;
  int           sent_items  = 0;
  int           idle_cycles = 0;
  int           tx_left = 0;
  bit           tx_calm = 1'b0;
  int           rx_left = 0;
  bit           rx_calm = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(4, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bit parse_char(input logic kind, input logic [CH_W-1:0] ch,
                                    output addr_result_t res);
    res = '0;
    if (kind == KIND_END) begin
      res.bad = parse_state.err || parse_state.dots != 3'(DOTS_FULL) ||
                parse_state.digits == 2'd0 || parse_state.octet > OCTET_MAX;
      res.address = res.bad ? '0 : {parse_state.partial, parse_state.octet[7:0]};
      parse_state = '0;
      return 1'b1;
    end
    if (!parse_state.err) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (parse_state.digits == DIGITS_MAX) begin
          parse_state.err = 1'b1;
        end else begin
          parse_state.octet = parse_state.octet * RADIX + OCTET_W'(ch - CH_ZERO);
          parse_state.digits++;
        end
      end else if (ch == CH_DOT) begin
        if (parse_state.dots >= 3'(DOTS_FULL) || parse_state.digits == 2'd0 ||
            parse_state.octet > OCTET_MAX) begin
          parse_state.err = 1'b1;
        end else begin
          parse_state.partial = {parse_state.partial[PART_W-9:0], parse_state.octet[7:0]};
          parse_state.dots++;
          parse_state.digits = '0;
          parse_state.octet = '0;
        end
      end else begin
        parse_state.err = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic send_item(input char_item_t item);
    int           gap;
    addr_result_t predicted;
    addr_result_t typed;
    gap = draw_wait(tx_left, tx_calm);
    if (gap > 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.kind <= item.kind;
    chars_if.ch <= item.ch;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent_items++;
    if (parse_char(item.kind, item.ch, predicted)) begin
      if (item.fixed) begin
        typed.address = item.address;
        typed.bad = item.bad;
        pending_addrs.push_back(typed);
      end else begin
        pending_addrs.push_back(predicted);
      end
    end
  endtask

  task automatic send_random_string();
    logic [CH_W-1:0] txt [$];
    logic [CH_W-1:0] digs [$];
    int              mode;
    int              octets;
    int              hit;
    int              val;
    int              wid;
    int              v;
    mode = $urandom_range(0, 15);
    if (mode == 15) begin
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 3))
          0:       txt.push_back(CH_DOT);
          1:       txt.push_back(CH_W'($urandom_range(CH_ZERO, CH_NINE)));
          default: txt.push_back(CH_W'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      octets = (mode == 11) ? $urandom_range(1, 3) : (mode == 12) ? 5 : 4;
      hit = $urandom_range(0, octets - 1);
      for (int i = 0; i < octets; i++) begin
        if (i > 0) txt.push_back(CH_DOT);
        case ($urandom_range(0, 9))
          0:       val = 0;
          1:       val = 255;
          2:       val = $urandom_range(0, 9);
          3:       val = $urandom_range(100, 255);
          default: val = $urandom_range(0, 255);
        endcase
        if (i == hit && mode == 8) val = $urandom_range(256, 999);
        wid = (val >= 100) ? 3 : (val >= 10) ? 2 : 1;
        if ($urandom_range(0, 3) == 0) wid = $urandom_range(wid, 3);
        if (i == hit && mode == 9) wid = 4;
        if (!(i == hit && mode == 10)) begin
          digs.delete();
          v = val;
          repeat (wid) begin
            digs.push_front(CH_ZERO + CH_W'(v % 10));
            v = v / 10;
          end
          txt = {txt, digs};
        end
      end
      if (mode == 14) txt.push_back(CH_DOT);
      if (mode == 13) txt.insert($urandom_range(0, txt.size()), CH_W'($urandom_range(0, 255)));
    end
    foreach (txt[i]) send_item('{KIND_CHAR, txt[i], 1'b0, '0, 1'b0});
    send_item('{KIND_END, CH_W'($urandom_range(0, 255)), 1'b0, '0, 1'b0});
  endtask

  initial begin
    int gap;
    result_if.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_wait(rx_left, rx_calm);
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
      while (!(result_if.valid && result_if.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    addr_result_t want;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pending_addrs.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: address %h bad %b",
                                    result_if.address, result_if.bad));
        end else begin
          want = pending_addrs.pop_front();
          if (result_if.address !== want.address)
            report_mismatch($sformatf("address %h, expected %h",
                                      result_if.address, want.address));
          if (result_if.bad !== want.bad)
            report_mismatch($sformatf("bad %b, expected %b", result_if.bad, want.bad));
        end
      end
      if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int strings;
    chars_if.valid <= 1'b0;
    chars_if.kind <= KIND_CHAR;
    chars_if.ch <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SHAPES; i++) begin
      for (int j = 0; j < shape_text[i].len(); j++)
        send_item('{KIND_CHAR, CH_W'(shape_text[i][j]), 1'b0, '0, 1'b0});
      send_item('{KIND_END, (i == 0) ? 8'hFF : 8'h00, 1'b1, shape_addr[i], shape_bad[i]});
    end

    strings = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (strings % 40 == 39) begin
        chars_if.valid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge clk);
      end
      send_random_string();
      strings++;
    end
    chars_if.valid <= 1'b0;

    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_addrs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_addrs.size()));
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
